// ===== sv/ola_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ola_pkg;

    // fixed field widths of the result transfer
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int VALUE_W  = 32;

    // request kinds
    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // one result item, status in the lowest bits
    typedef struct packed {
        logic [VALUE_W-1:0]  tail_value;
        logic [VALUE_W-1:0]  head_value;
        logic                now_empty;
        logic [COUNT_W-1:0]  entry_count;
        logic [STATUS_W-1:0] status;
    } ola_result_t;

    localparam int RESULT_W = $bits(ola_result_t);

endpackage

`default_nettype wire

// ===== sv/ola_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ola_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/ola_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ola_ctrl
    import ola_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_W     = 4,
    parameter int CNT_W      = 5
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // request side
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire logic                  req_type,
    input  wire logic [VALUE_W-1:0]    req_value,
    // result side
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output ola_result_t                res,
    // list storage
    output logic                       ram_wr_en,
    output logic      [ADDR_W-1:0]     ram_wr_addr,
    output logic      [DATA_WIDTH-1:0] ram_wr_data,
    output logic                       ram_rd_en,
    output logic      [ADDR_W-1:0]     ram_rd_addr,
    input  wire logic [DATA_WIDTH-1:0] ram_rd_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [1:0]            state_reg,     state_next;
    logic [CNT_W-1:0]      count_reg,     count_next;
    logic [DATA_WIDTH-1:0] head_reg,      head_next;
    logic [DATA_WIDTH-1:0] tail_reg,      tail_next;
    logic [DATA_WIDTH-1:0] key_reg,       key_next;
    logic [CNT_W-1:0]      rd_idx_reg,    rd_idx_next;
    logic [CNT_W-1:0]      chk_idx_reg,   chk_idx_next;
    logic                  chk_vld_reg,   chk_vld_next;
    logic                  found_reg,     found_next;
    logic                  kept_reg,      kept_next;
    logic [DATA_WIDTH-1:0] scan_head_reg, scan_head_next;
    logic [DATA_WIDTH-1:0] scan_tail_reg, scan_tail_next;
    logic [STATUS_W-1:0]   status_reg,    status_next;
    logic                  empty_reg,     empty_next;

    logic [63:0]           in_sext;
    logic [DATA_WIDTH-1:0] in_v;
    logic [CNT_W-1:0]      move_idx;
    logic                  key_hit;
    logic [63:0]           head_wide;
    logic [63:0]           tail_wide;
    logic [15:0]           count_wide;

    // value kept on its low DATA_WIDTH bits after sign extension
    assign in_sext   = {{32{req_value[VALUE_W-1]}}, req_value};
    assign in_v      = in_sext[DATA_WIDTH-1:0];
    assign move_idx  = chk_idx_reg - 1'b1;
    assign key_hit   = (ram_rd_data == key_reg);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        key_next       = key_reg;
        rd_idx_next    = rd_idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_vld_next   = 1'b0;
        found_next     = found_reg;
        kept_next      = kept_reg;
        scan_head_next = scan_head_reg;
        scan_tail_next = scan_tail_reg;
        status_next    = status_reg;
        empty_next     = empty_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = count_reg[ADDR_W-1:0];
        ram_wr_data    = in_v;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = rd_idx_reg[ADDR_W-1:0];
        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    key_next   = in_v;
                    empty_next = 1'b0;
                    if (req_type == REQ_APPEND) begin
                        state_next = S_RESP;
                        if (count_reg == CAP_CNT) begin
                            status_next = ST_FULL;
                        end else begin
                            ram_wr_en   = 1'b1;
                            count_next  = count_reg + 1'b1;
                            tail_next   = in_v;
                            status_next = ST_DONE;
                            if (count_reg == '0) begin
                                head_next = in_v;
                            end
                        end
                    end else if (count_reg == '0) begin
                        status_next = ST_EMPTY;
                        state_next  = S_RESP;
                    end else begin
                        rd_idx_next = '0;
                        found_next  = 1'b0;
                        kept_next   = 1'b0;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // issue the next read
                if (rd_idx_reg != count_reg) begin
                    ram_rd_en    = 1'b1;
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_idx_reg;
                end
                // compare the returned entry, close up the gap behind a match
                if (chk_vld_reg) begin
                    if (!found_reg && key_hit) begin
                        found_next = 1'b1;
                    end else begin
                        if (found_reg) begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = move_idx[ADDR_W-1:0];
                            ram_wr_data = ram_rd_data;
                        end
                        if (!kept_reg) begin
                            scan_head_next = ram_rd_data;
                            kept_next      = 1'b1;
                        end
                        scan_tail_next = ram_rd_data;
                    end
                end
                // all entries seen
                if (!chk_vld_reg && rd_idx_reg == count_reg) begin
                    state_next = S_RESP;
                    if (found_reg) begin
                        count_next  = count_reg - 1'b1;
                        head_next   = scan_head_reg;
                        tail_next   = scan_tail_reg;
                        status_next = ST_DONE;
                        empty_next  = (count_reg == CNT_W'(1));
                    end else begin
                        status_next = ST_NOT_FOUND;
                    end
                end
            end
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            chk_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            kept_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            chk_vld_reg <= chk_vld_next;
            found_reg   <= found_next;
            kept_reg    <= kept_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        head_reg      <= head_next;
        tail_reg      <= tail_next;
        key_reg       <= key_next;
        rd_idx_reg    <= rd_idx_next;
        chk_idx_reg   <= chk_idx_next;
        scan_head_reg <= scan_head_next;
        scan_tail_reg <= scan_tail_next;
        status_reg    <= status_next;
        empty_reg     <= empty_next;
    end

    // result build, head and tail read as zero on an empty list
    assign head_wide  = 64'(head_reg);
    assign tail_wide  = 64'(tail_reg);
    assign count_wide = 16'(count_reg);

    assign req_ready       = (state_reg == S_IDLE);
    assign res_valid       = (state_reg == S_RESP);
    assign res.status      = status_reg;
    assign res.entry_count = count_wide[COUNT_W-1:0];
    assign res.now_empty   = empty_reg;
    assign res.head_value  = (count_reg != '0) ? head_wide[VALUE_W-1:0] : '0;
    assign res.tail_value  = (count_reg != '0) ? tail_wide[VALUE_W-1:0] : '0;

endmodule

`default_nettype wire

// ===== sv/ordered_list_append_delete_core.sv =====
// Ordered list of up to CAPACITY values with append at the tail and delete
// of the first entry equal to a key.
// Input channel s_*: one transfer is one request; s_tuser[0] is the kind
// (0 append, 1 delete) and s_tdata carries the value or key.
// Output channel m_*: one transfer per request with status, entry count,
// became-empty flag and the head and tail values (zero on an empty list).
// An append, a rejected append and a delete on an empty list go straight
// to the result state; the result then passes to the output register and
// m_tvalid. A delete walks the list one entry per cycle through the single
// read port of the entry memory and closes up the gap with the write port
// in the same pass. s_tready is high only while no request is in progress,
// so a new request is not taken until the previous result has been handed
// to the output register.
// Results go to an output register, so the next request is taken while a
// result waits; with m_tready low and the register full, the next result
// holds the sequencer until the register drains.
// After reset the list is empty; the entry memory is not cleared and no
// entry is read before it was written.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_append_delete_core
    import ola_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [VALUE_W-1:0]  s_tdata,   // [31:0] item_value
    input  wire logic                s_tuser,   // [0] req_type
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [1:0] status, [6:2] entry_count, [7] now_empty,
    // [39:8] head_value, [71:40] tail_value
    output logic      [RESULT_W-1:0] m_tdata
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic                  res_valid;
    logic                  res_ready;
    ola_result_t           res;
    logic                  ram_wr_en;
    logic [ADDR_W-1:0]     ram_wr_addr;
    logic [DATA_WIDTH-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [ADDR_W-1:0]     ram_rd_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    logic                  out_valid_reg, out_valid_next;
    ola_result_t           out_data_reg,  out_data_next;

    ola_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_type    (s_tuser),
        .req_value   (s_tdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    ola_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_WIDTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // output register
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    // a taken request keeps the sequencer busy in the next cycle
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous one still in progress");

    // became-empty only on a completed delete that left nothing
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_data_reg.now_empty |->
            out_data_reg.status == ST_DONE && out_data_reg.entry_count == '0)
        else $error("now_empty with a nonzero count or failed request");

    // a full report carries the capacity as count
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_data_reg.status == ST_FULL |->
            out_data_reg.entry_count == COUNT_W'(CAPACITY))
        else $error("list full reported below capacity");

    // an empty report comes from an empty list
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_data_reg.status == ST_EMPTY |->
            out_data_reg.entry_count == '0 && out_data_reg.head_value == '0)
        else $error("empty status with entries present");
`endif

endmodule

`default_nettype wire
